// ----- sv/fmm_pkg.sv -----
// Package for the formula molar mass parser: beat types, status and class codes,
// the element weight table and character class helpers. No dependencies.
package fmm_pkg;

	localparam int WEIGHT_W = 48;
	localparam int ELEM_W = 19;
	localparam int EPOS_W = 11;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SYNTAX = 3'd1,
		ST_DEPTH  = 3'd2,
		ST_WOVF   = 3'd3,
		ST_ZERO   = 3'd4
	} status_t;

	// What the previous character left behind.
	typedef enum logic [1:0] {
		CL_START,
		CL_OPEN,
		CL_TERM,
		CL_COUNT
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} fmm_char_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight_milli;
		status_t             status;
		logic [EPOS_W-1:0]   error_position;
	} fmm_res_t;

	// Parser state at the end of a formula, handed to the finishing stage.
	typedef struct packed {
		logic [WEIGHT_W-1:0] sum0;
		logic [WEIGHT_W-1:0] pv;
		logic [WEIGHT_W-1:0] prod;
		logic                ovf;
		logic                has;
		logic [7:0]          held;
		cls_t                prev;
		logic                open_grp;
		status_t             status;
	} fmm_snap_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Weight in thousandths of a dalton; zero when the symbol is unknown.
	// A one-letter symbol is looked up with a NUL second character.
	function automatic logic [ELEM_W-1:0] fmm_lookup(input logic [7:0] a, input logic [7:0] b);
		logic [ELEM_W-1:0] w;
		case ({a, b})
			{"H", 8'h00}: w = 19'd1007;
			"He": w = 19'd4003;
			"Li": w = 19'd6941;
			"Be": w = 19'd9012;
			{"B", 8'h00}: w = 19'd10810;
			{"C", 8'h00}: w = 19'd12010;
			{"N", 8'h00}: w = 19'd14010;
			{"O", 8'h00}: w = 19'd16000;
			{"F", 8'h00}: w = 19'd19000;
			"Ne": w = 19'd20180;
			"Na": w = 19'd22990;
			"Mg": w = 19'd24310;
			"Al": w = 19'd26980;
			"Si": w = 19'd28090;
			{"P", 8'h00}: w = 19'd30980;
			{"S", 8'h00}: w = 19'd32070;
			"Cl": w = 19'd35450;
			"Ar": w = 19'd39950;
			{"K", 8'h00}: w = 19'd39100;
			"Ca": w = 19'd40080;
			"Sc": w = 19'd44960;
			"Ti": w = 19'd47870;
			{"V", 8'h00}: w = 19'd50940;
			"Cr": w = 19'd52000;
			"Mn": w = 19'd54940;
			"Fe": w = 19'd55850;
			"Co": w = 19'd58930;
			"Ni": w = 19'd58690;
			"Cu": w = 19'd63540;
			"Zn": w = 19'd65380;
			"Ga": w = 19'd69720;
			"Ge": w = 19'd72630;
			"As": w = 19'd74920;
			"Se": w = 19'd78960;
			"Br": w = 19'd79900;
			"Kr": w = 19'd83800;
			"Rb": w = 19'd85470;
			"Sr": w = 19'd87620;
			{"Y", 8'h00}: w = 19'd88900;
			"Zr": w = 19'd91220;
			"Nb": w = 19'd92910;
			"Mo": w = 19'd95960;
			"Tc": w = 19'd97910;
			"Ru": w = 19'd101100;
			"Rh": w = 19'd102900;
			"Pd": w = 19'd106400;
			"Ag": w = 19'd107900;
			"Cd": w = 19'd112400;
			"In": w = 19'd114800;
			"Sn": w = 19'd118700;
			"Sb": w = 19'd121800;
			"Te": w = 19'd127600;
			{"I", 8'h00}: w = 19'd126900;
			"Xe": w = 19'd131300;
			"Cs": w = 19'd132900;
			"Ba": w = 19'd137300;
			"La": w = 19'd138900;
			"Ce": w = 19'd140100;
			"Pr": w = 19'd140900;
			"Nd": w = 19'd144200;
			"Pm": w = 19'd145000;
			"Sm": w = 19'd150400;
			"Eu": w = 19'd151900;
			"Gd": w = 19'd157300;
			"Tb": w = 19'd158900;
			"Dy": w = 19'd162500;
			"Ho": w = 19'd164900;
			"Er": w = 19'd167300;
			"Tm": w = 19'd168900;
			"Yb": w = 19'd173100;
			"Lu": w = 19'd175000;
			"Hf": w = 19'd178500;
			"Ta": w = 19'd181000;
			{"W", 8'h00}: w = 19'd183800;
			"Re": w = 19'd186200;
			"Os": w = 19'd190200;
			"Ir": w = 19'd192200;
			"Pt": w = 19'd195100;
			"Au": w = 19'd197000;
			"Hg": w = 19'd200600;
			"Tl": w = 19'd204400;
			"Pb": w = 19'd207200;
			"Bi": w = 19'd209000;
			"Po": w = 19'd209000;
			"At": w = 19'd210000;
			"Rn": w = 19'd222000;
			"Fr": w = 19'd223000;
			"Ra": w = 19'd226000;
			"Ac": w = 19'd227000;
			"Th": w = 19'd232000;
			"Pa": w = 19'd231000;
			{"U", 8'h00}: w = 19'd238000;
			"Np": w = 19'd237000;
			"Pu": w = 19'd244000;
			"Am": w = 19'd243000;
			"Cm": w = 19'd247000;
			"Bk": w = 19'd247000;
			"Cf": w = 19'd251000;
			"Es": w = 19'd252000;
			"Fm": w = 19'd257000;
			"Md": w = 19'd258000;
			"No": w = 19'd259000;
			"Lr": w = 19'd263000;
			"Rf": w = 19'd261000;
			"Db": w = 19'd262000;
			"Sg": w = 19'd266000;
			"Bh": w = 19'd264000;
			"Hs": w = 19'd277000;
			"Mt": w = 19'd268000;
			"Ds": w = 19'd271000;
			"Rg": w = 19'd272000;
			"Cn": w = 19'd285000;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- sv/fmm_parse.sv -----
// Per-character parser: symbol matching, counts, the group stack and sticky errors.
// Depends on fmm_pkg. Presents the end-of-formula state to fmm_finish.
module fmm_parse import fmm_pkg::*; #(
	parameter int MAX_DEPTH  = 8,
	parameter int MAX_LEN    = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  fmm_char_t                         beat,
	output fmm_snap_t                         snap,
	output logic [$clog2(MAX_LEN+2)-1:0]      fail_pos,
	output logic [$clog2(MAX_LEN+2)-1:0]      end_pos
);

	localparam int LV_W  = $clog2(MAX_DEPTH + 1);
	localparam int POS_W = $clog2(MAX_LEN + 2);
	localparam int CB    = COUNT_BITS;

	logic [WEIGHT_W-1:0] sums_q [0:MAX_DEPTH];
	logic [LV_W-1:0]     nest_q;
	logic [7:0]          held_q;
	logic [WEIGHT_W-1:0] pv_q;
	logic [CB-1:0]       cnt_q;
	logic                has_q;
	logic [WEIGHT_W-1:0] prod_q;
	logic                ovf_q;
	cls_t                prev_q;
	logic [POS_W-1:0]    pos_q;
	status_t             st_q;
	logic [POS_W-1:0]    fpos_q;

	logic [WEIGHT_W-1:0] n_sums [0:MAX_DEPTH];
	logic [LV_W-1:0]     n_nest;
	logic [7:0]          n_held;
	logic [WEIGHT_W-1:0] n_pv;
	logic [CB-1:0]       n_cnt;
	logic                n_has;
	logic [WEIGHT_W-1:0] n_prod;
	logic                n_ovf;
	cls_t                n_prev;
	logic [POS_W-1:0]    n_pos;
	status_t             n_st;
	logic [POS_W-1:0]    n_fpos;

	logic [7:0]          c;
	logic [3:0]          dg;
	logic                go;
	logic [ELEM_W-1:0]   w1;
	logic [ELEM_W-1:0]   w2;
	logic                can_fl;
	logic [WEIGHT_W-1:0] fl_v;
	logic [WEIGHT_W:0]   fl_sum;
	logic                fl_bad;
	logic [51:0]         pm;
	logic [52:0]         big;
	logic [CB+3:0]       cn;
	logic                sat;
	logic [WEIGHT_W+CB-1:0] ps;

	assign c  = beat.ch;
	assign dg = 4'(c - 8'h30);

	always_comb begin
		n_sums = sums_q;
		n_nest = nest_q;
		n_held = held_q;
		n_pv   = pv_q;
		n_cnt  = cnt_q;
		n_has  = has_q;
		n_prod = prod_q;
		n_ovf  = ovf_q;
		n_prev = prev_q;
		n_st   = st_q;
		n_fpos = fpos_q;
		go     = 1'b0;
		w1     = fmm_lookup(held_q, 8'h00);
		w2     = is_letter(c) ? fmm_lookup(held_q, c) : '0;
		can_fl = 1'b0;
		fl_v   = '0;
		fl_sum = '0;
		fl_bad = 1'b0;
		pm     = '0;
		big    = '0;
		cn     = '0;
		sat    = 1'b0;
		ps     = '0;
		if (st_q == ST_OK) begin
			if (pos_q >= POS_W'(MAX_LEN)) begin
				n_st   = ST_SYNTAX;
				n_fpos = POS_W'(MAX_LEN);
			end else begin
				go = 1'b1;
				// A held letter is settled first: two-letter symbol, else one letter.
				if (held_q != 8'h00) begin
					n_held = 8'h00;
					if (w2 != '0) begin
						n_pv   = WEIGHT_W'(w2);
						n_has  = 1'b0;
						n_cnt  = '0;
						n_prod = '0;
						n_ovf  = 1'b0;
						n_prev = CL_TERM;
						go     = 1'b0;
					end else if (w1 == '0) begin
						n_st   = ST_SYNTAX;
						n_fpos = pos_q - POS_W'(1);
						go     = 1'b0;
					end else begin
						n_pv   = WEIGHT_W'(w1);
						n_has  = 1'b0;
						n_cnt  = '0;
						n_prev = CL_TERM;
					end
				end
			end
		end
		if (go) begin
			can_fl = (n_prev == CL_TERM) || (n_prev == CL_COUNT);
			fl_v   = n_has ? n_prod : n_pv;
			fl_sum = {1'b0, sums_q[nest_q]} + {1'b0, fl_v};
			fl_bad = can_fl && ((n_has && n_ovf) || fl_sum[WEIGHT_W]);
			pm     = 52'(n_pv) * 52'(dg);
			big    = 53'(n_prod) * 53'(10) + 53'(pm);
			cn     = (CB+4)'(n_cnt) * (CB+4)'(10) + (CB+4)'(dg);
			sat    = |cn[CB+3:CB];
			ps     = {n_pv, {CB{1'b0}}} - (WEIGHT_W+CB)'(n_pv);
			if (is_letter(c)) begin
				if (fl_bad) begin
					n_st   = ST_WOVF;
					n_fpos = pos_q;
				end else begin
					if (can_fl) begin
						n_sums[nest_q] = fl_sum[WEIGHT_W-1:0];
						n_pv   = '0;
						n_cnt  = '0;
						n_has  = 1'b0;
					end
					n_held = c;
				end
			end else if (is_digit(c)) begin
				if (n_prev == CL_TERM) begin
					n_has  = 1'b1;
					n_cnt  = CB'(dg);
					n_prod = pm[WEIGHT_W-1:0];
					n_ovf  = |pm[51:WEIGHT_W];
					n_prev = CL_COUNT;
				end else if (n_prev == CL_COUNT) begin
					// Product tracks pending value times count, with a sticky overflow.
					n_cnt = sat ? {CB{1'b1}} : cn[CB-1:0];
					if (sat) begin
						n_prod = ps[WEIGHT_W-1:0];
						n_ovf  = n_ovf | (|ps[WEIGHT_W+CB-1:WEIGHT_W]);
					end else begin
						n_prod = big[WEIGHT_W-1:0];
						n_ovf  = n_ovf | (|big[52:WEIGHT_W]);
					end
				end else begin
					n_st   = ST_SYNTAX;
					n_fpos = pos_q;
				end
			end else if (c == "(") begin
				if (fl_bad) begin
					n_st   = ST_WOVF;
					n_fpos = pos_q;
				end else if (nest_q >= LV_W'(MAX_DEPTH)) begin
					n_st   = ST_DEPTH;
					n_fpos = pos_q;
				end else begin
					if (can_fl) begin
						n_sums[nest_q] = fl_sum[WEIGHT_W-1:0];
						n_pv   = '0;
						n_cnt  = '0;
						n_has  = 1'b0;
					end
					n_nest = nest_q + LV_W'(1);
					n_sums[nest_q + LV_W'(1)] = '0;
					n_prev = CL_OPEN;
				end
			end else if (c == ")") begin
				if (n_prev == CL_START || n_prev == CL_OPEN || nest_q == '0) begin
					n_st   = ST_SYNTAX;
					n_fpos = pos_q;
				end else if (fl_bad) begin
					n_st   = ST_WOVF;
					n_fpos = pos_q;
				end else begin
					n_pv   = fl_sum[WEIGHT_W-1:0];
					n_sums[nest_q] = '0;
					n_nest = nest_q - LV_W'(1);
					n_cnt  = '0;
					n_has  = 1'b0;
					n_prev = CL_TERM;
				end
			end else begin
				n_st   = ST_SYNTAX;
				n_fpos = pos_q;
			end
		end
		n_pos = (pos_q < POS_W'(MAX_LEN)) ? pos_q + POS_W'(1) : pos_q;
	end

	always_comb begin
		snap.sum0     = n_sums[0];
		snap.pv       = n_pv;
		snap.prod     = n_prod;
		snap.ovf      = n_ovf;
		snap.has      = n_has;
		snap.held     = n_held;
		snap.prev     = n_prev;
		snap.open_grp = (n_nest != '0);
		snap.status   = n_st;
	end

	assign fail_pos = n_fpos;
	assign end_pos  = pos_q;

	// The last beat of a formula returns everything to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_DEPTH; i++) sums_q[i] <= '0;
			nest_q <= '0;
			held_q <= 8'h00;
			pv_q   <= '0;
			cnt_q  <= '0;
			has_q  <= 1'b0;
			prod_q <= '0;
			ovf_q  <= 1'b0;
			prev_q <= CL_START;
			pos_q  <= '0;
			st_q   <= ST_OK;
			fpos_q <= '0;
		end else if (take) begin
			if (beat.last) begin
				for (int i = 0; i <= MAX_DEPTH; i++) sums_q[i] <= '0;
				nest_q <= '0;
				held_q <= 8'h00;
				pv_q   <= '0;
				cnt_q  <= '0;
				has_q  <= 1'b0;
				prod_q <= '0;
				ovf_q  <= 1'b0;
				prev_q <= CL_START;
				pos_q  <= '0;
				st_q   <= ST_OK;
				fpos_q <= '0;
			end else begin
				sums_q <= n_sums;
				nest_q <= n_nest;
				held_q <= n_held;
				pv_q   <= n_pv;
				cnt_q  <= n_cnt;
				has_q  <= n_has;
				prod_q <= n_prod;
				ovf_q  <= n_ovf;
				prev_q <= n_prev;
				pos_q  <= n_pos;
				st_q   <= n_st;
				fpos_q <= n_fpos;
			end
		end
	end

endmodule

// ----- sv/fmm_finish.sv -----
// End-of-formula stage: settles a held letter, the last term and the final checks,
// then holds the result beat for the receiver. Depends on fmm_pkg.
module fmm_finish import fmm_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  fmm_snap_t                     snap,
	input  logic [$clog2(MAX_LEN+2)-1:0]  fail_pos,
	input  logic [$clog2(MAX_LEN+2)-1:0]  end_pos,
	output logic                          ready,
	output logic                          mass_valid,
	input  logic                          mass_stall,
	output fmm_res_t                      mass_data
);

	localparam int POS_W = $clog2(MAX_LEN + 2);

	logic             snap_v_s1;
	fmm_snap_t        snap_s1;
	logic [POS_W-1:0] fpos_s1;
	logic [POS_W-1:0] epos_s1;
	logic             out_free;
	fmm_res_t         res;

	status_t             st;
	logic [POS_W-1:0]    fp;
	logic [WEIGHT_W-1:0] sum0;
	logic [WEIGHT_W-1:0] pv;
	logic                has;
	cls_t                prev;
	logic [ELEM_W-1:0]   w1;
	logic [POS_W-1:0]    endp;
	logic [WEIGHT_W-1:0] v;
	logic [WEIGHT_W:0]   sum;
	logic [31:0]         fp_wide;

	assign out_free = !mass_valid || !mass_stall;
	assign ready    = !snap_v_s1 || out_free;

	always_comb begin
		st   = snap_s1.status;
		fp   = fpos_s1;
		sum0 = snap_s1.sum0;
		pv   = snap_s1.pv;
		has  = snap_s1.has;
		prev = snap_s1.prev;
		w1   = fmm_lookup(snap_s1.held, 8'h00);
		endp = epos_s1 + POS_W'(1);
		v    = '0;
		sum  = '0;
		if (st == ST_OK && snap_s1.held != 8'h00) begin
			if (w1 == '0) begin
				st = ST_SYNTAX;
				fp = epos_s1;
			end else begin
				pv   = WEIGHT_W'(w1);
				has  = 1'b0;
				prev = CL_TERM;
			end
		end
		if (st == ST_OK) begin
			if (prev == CL_START || prev == CL_OPEN || snap_s1.open_grp) begin
				st = ST_SYNTAX;
				fp = endp;
			end else begin
				v   = has ? snap_s1.prod : pv;
				sum = {1'b0, sum0} + {1'b0, v};
				if ((has && snap_s1.ovf) || sum[WEIGHT_W]) begin
					st = ST_WOVF;
					fp = endp;
				end else begin
					sum0 = sum[WEIGHT_W-1:0];
					if (sum0 == '0) begin
						st = ST_ZERO;
						fp = endp;
					end
				end
			end
		end
		fp_wide = 32'(fp);
		res.status = st;
		res.error_position = (st == ST_OK) ? '0 : fp_wide[EPOS_W-1:0];
		case (st)
			ST_OK:   res.weight_milli = sum0;
			ST_WOVF: res.weight_milli = '1;
			default: res.weight_milli = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1  <= 1'b0;
			mass_valid <= 1'b0;
		end else begin
			if (ready) snap_v_s1 <= load;
			if (out_free) mass_valid <= snap_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			snap_s1 <= snap;
			fpos_s1 <= fail_pos;
			epos_s1 <= end_pos;
		end
		if (out_free && snap_v_s1) mass_data <= res;
	end

	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mass_valid && mass_data.status == ST_OK |->
			mass_data.weight_milli != '0 && mass_data.error_position == '0)
		else $error("ok result with zero weight or a failure position");

	a_wovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		mass_valid && mass_data.status == ST_WOVF |-> mass_data.weight_milli == '1)
		else $error("weight overflow not saturated");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mass_valid && mass_data.status != ST_OK && mass_data.status != ST_WOVF |->
			mass_data.weight_milli == '0)
		else $error("failed result carries a weight");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		snap_v_s1 && out_free |=> mass_valid)
		else $error("finished formula lost between stages");

endmodule

// ----- sv/formula_molar_mass_parser.sv -----
// Top level of the formula molar mass parser.
// Depends on fmm_pkg, fmm_parse and fmm_finish.
//
// Usage: the formula arrives one ASCII character per beat on the char channel,
// with last set on its final character. One result beat per formula leaves on
// the mass channel: weight in thousandths of a dalton, a status code and the
// position of the first failing character.
// Throughput: one character per cycle while char_stall is low; the parser
// state updates in the cycle a character is taken, through one table lookup,
// one add and the stack. After the last character is taken, the result passes
// through one end-of-formula register, then the result register.
// Reset clears the group stack, the position counter and the sticky status;
// the block is ready at once. The last character of a formula does the same,
// so the next formula may follow in the next cycle.
// When the receiver stalls, the result holds and one more finished formula can
// wait behind it; after that char_stall rises until the result is taken.
module formula_molar_mass_parser import fmm_pkg::*; #(
	parameter int MAX_DEPTH  = 8,
	parameter int MAX_LEN    = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  fmm_char_t char_data,
	output logic      mass_valid,
	input  logic      mass_stall,
	output fmm_res_t  mass_data
);

	localparam int POS_W = $clog2(MAX_LEN + 2);

	logic             ready;
	logic             take;
	fmm_snap_t        snap;
	logic [POS_W-1:0] fail_pos;
	logic [POS_W-1:0] end_pos;

	assign char_stall = !ready;
	assign take       = char_valid && ready;

	fmm_parse #(
		.MAX_DEPTH (MAX_DEPTH),
		.MAX_LEN   (MAX_LEN),
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.beat    (char_data),
		.snap    (snap),
		.fail_pos(fail_pos),
		.end_pos (end_pos)
	);

	fmm_finish #(
		.MAX_LEN(MAX_LEN)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && char_data.last),
		.snap      (snap),
		.fail_pos  (fail_pos),
		.end_pos   (end_pos),
		.ready     (ready),
		.mass_valid(mass_valid),
		.mass_stall(mass_stall),
		.mass_data (mass_data)
	);

endmodule
